// ----- rtl/isp_cfe_pkg.sv -----
`default_nettype none

package isp_cfe_pkg;

  // request codes
  localparam logic [2:0] CMD_READ_FLASH   = 3'd0;
  localparam logic [2:0] CMD_WRITE_FLASH  = 3'd1;
  localparam logic [2:0] CMD_COMMIT_PAGE  = 3'd2;
  localparam logic [2:0] CMD_READ_EEPROM  = 3'd3;
  localparam logic [2:0] CMD_WRITE_EEPROM = 3'd4;

  // instruction opcodes
  localparam logic [7:0] OP_LOAD_EXT   = 8'h4D;
  localparam logic [7:0] OP_READ_PROG  = 8'h20;
  localparam logic [7:0] OP_WRITE_PROG = 8'h40;
  localparam logic [7:0] OP_COMMIT     = 8'h4C;
  localparam logic [7:0] OP_READ_EE    = 8'hA0;
  localparam logic [7:0] OP_WRITE_EE   = 8'hC0;
  localparam logic [7:0] EXT_RESET     = 8'hFF;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  typedef struct packed {
    logic [2:0]  command;
    logic [24:0] address;
    logic [7:0]  data_byte;
  } req_word_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_last;
  } spi_word_t;

endpackage

`default_nettype wire

// ----- rtl/isp_command_frame_encoder.sv -----
`default_nettype none

// Serial programming instruction encoder. Each accepted request word is
// expanded into its 4-byte instruction, preceded by a 4-byte load-extended-
// address frame when a flash request's address bits 24..17 differ from the
// cached value (reset value 0xFF). Bytes leave one per cycle, while out_ready
// does not stall them, through a registered output, frame_last marking the
// final byte of a request; unused command codes are accepted and produce
// nothing. A request occupies the frame buffer until each of its bytes has
// been emitted; the next request is taken in the cycle the buffer hands over
// its last byte, so 4- and 8-byte requests stream without gaps.
module isp_command_frame_encoder
  import isp_cfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire req_word_t in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output spi_word_t      out_word
);

  logic [7:0]       ext_cache_r, ext_cache_nxt;
  logic             buf_vld_r, buf_vld_nxt;
  logic [IDX_W-1:0] buf_idx_r, buf_idx_nxt;
  logic [7:0]       buf_bytes_r [FRAME_BYTES];
  logic [7:0]       frame [FRAME_BYTES];
  logic             out_vld_r, out_vld_nxt;
  spi_word_t        out_word_r, out_word_nxt;

  logic       in_acc, move, buf_done;
  logic       is_flash, is_valid_cmd, need_ext;
  logic [7:0] ext_hi, op_byte, addr_hi, addr_lo, last_byte;

  assign move     = buf_vld_r && (!out_vld_r || out_ready);
  assign buf_done = move && (buf_idx_r == IDX_W'(FRAME_BYTES - 1));
  assign in_ready = !buf_vld_r || buf_done;
  assign in_acc   = in_valid && in_ready;

  // encode the incoming request
  always_comb begin
    is_valid_cmd = (in_word.command <= CMD_WRITE_EEPROM);
    is_flash     = (in_word.command <= CMD_COMMIT_PAGE);
    ext_hi       = in_word.address[24:17];
    need_ext     = is_flash && (ext_hi != ext_cache_r);
    op_byte      = OP_COMMIT;
    addr_hi      = in_word.address[16:9];
    addr_lo      = in_word.address[8:1];
    last_byte    = 8'h00;
    unique case (in_word.command)
      CMD_READ_FLASH:   op_byte = OP_READ_PROG | {4'b0, in_word.address[0], 3'b0};
      CMD_WRITE_FLASH: begin
        op_byte   = OP_WRITE_PROG | {4'b0, in_word.address[0], 3'b0};
        last_byte = in_word.data_byte;
      end
      CMD_COMMIT_PAGE:  op_byte = OP_COMMIT;
      CMD_READ_EEPROM: begin
        op_byte = OP_READ_EE;
        addr_hi = in_word.address[15:8];
        addr_lo = in_word.address[7:0];
      end
      CMD_WRITE_EEPROM: begin
        op_byte   = OP_WRITE_EE;
        addr_hi   = in_word.address[15:8];
        addr_lo   = in_word.address[7:0];
        last_byte = in_word.data_byte;
      end
      default: op_byte = OP_COMMIT;
    endcase
    frame[0] = OP_LOAD_EXT;
    frame[1] = 8'h00;
    frame[2] = ext_hi;
    frame[3] = 8'h00;
    frame[4] = op_byte;
    frame[5] = addr_hi;
    frame[6] = addr_lo;
    frame[7] = last_byte;
  end

  always_comb begin
    ext_cache_nxt = ext_cache_r;
    buf_vld_nxt   = buf_vld_r;
    buf_idx_nxt   = buf_idx_r;
    out_vld_nxt   = out_vld_r;
    out_word_nxt  = out_word_r;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (move) begin
      out_vld_nxt             = 1'b1;
      out_word_nxt.spi_byte   = buf_bytes_r[buf_idx_r];
      out_word_nxt.frame_last = (buf_idx_r == IDX_W'(FRAME_BYTES - 1));
      buf_idx_nxt             = buf_idx_r + 1'b1;
      if (buf_done) begin
        buf_vld_nxt = 1'b0;
      end
    end
    if (in_acc && is_valid_cmd) begin
      buf_vld_nxt = 1'b1;
      // skip the extended-address frame when the cache already matches
      buf_idx_nxt = need_ext ? IDX_W'(0) : IDX_W'(FRAME_BYTES / 2);
      if (is_flash) begin
        ext_cache_nxt = ext_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_cache_r <= EXT_RESET;
      buf_vld_r   <= 1'b0;
      buf_idx_r   <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      ext_cache_r <= ext_cache_nxt;
      buf_vld_r   <= buf_vld_nxt;
      buf_idx_r   <= buf_idx_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (in_acc) begin
      buf_bytes_r <= frame;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  // a flash request leaves its extended address in the cache
  a_cache_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_word.command <= CMD_COMMIT_PAGE)
      |=> ext_cache_r == $past(in_word.address[24:17]))
    else $error("extended address cache not updated");

  // no new request while the current frame still has bytes beyond this one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_vld_r && buf_idx_r != IDX_W'(FRAME_BYTES - 1)) |-> !in_ready)
    else $error("request accepted while frame in progress");

  // a byte moved out of the final buffer slot is flagged frame_last
  a_last_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    (move && buf_idx_r == IDX_W'(FRAME_BYTES - 1)) |=> out_valid && out_word.frame_last)
    else $error("final byte not flagged");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("outputs active after reset");

endmodule

`default_nettype wire
